### src/lpg_pkg.sv
`timescale 1ns / 1ps

package lpg_pkg;

    localparam int COORD_BITS_DEF = 13;
    localparam int ADDR_BITS_DEF  = 24;

    localparam int STRIDE_BITS = 16;
    localparam int BPP_BITS    = 4;
    localparam int DIM_BITS    = 13;
    localparam int COLOR_BITS  = 24;

    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 16'd7680;
    localparam logic [BPP_BITS-1:0]    BPP_RESET    = 4'd4;
    localparam logic [DIM_BITS-1:0]    WIDTH_RESET  = 13'd1920;
    localparam logic [DIM_BITS-1:0]    HEIGHT_RESET = 13'd1080;

    typedef enum logic [1:0] {
        REG_ROW_STRIDE   = 2'd0,
        REG_BYTES_PER_PX = 2'd1,
        REG_IMAGE_WIDTH  = 2'd2,
        REG_IMAGE_HEIGHT = 2'd3
    } reg_index_t;

    typedef enum logic {
        KIND_START   = 1'b0,
        KIND_ADVANCE = 1'b1
    } kind_t;

endpackage

### src/line_pixel_generator_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// request   in         in_valid / in_ready   kind, start_x, start_y, end_x, end_y, line_color
// pixel     out        out_valid / out_ready pixel_x, pixel_y, write_enable, byte_address,
//                                            pixel_color, last_pixel
// config    in         APB psel / penable    paddr, pwdata, prdata, pready
//
// One request per cycle while in_ready is high; an accepted request is registered in the line
// state, and its pixel moves from there into the output register once the output is free.
// The step update lands in the line state at accept, the address multiply-add runs from that
// state into the output register. Reset clears the configuration to its defaults and leaves no line in progress.
// A stalled output holds one pixel and one more pending in the line state, then
// in_ready drops. An advance with no line in progress is taken and yields no pixel.

module line_pixel_generator_unit #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF,
    parameter int ADDR_BITS  = lpg_pkg::ADDR_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lpg_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [lpg_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [lpg_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                kind,
    input  logic signed [COORD_BITS-1:0]        start_x,
    input  logic signed [COORD_BITS-1:0]        start_y,
    input  logic signed [COORD_BITS-1:0]        end_x,
    input  logic signed [COORD_BITS-1:0]        end_y,
    input  logic [lpg_pkg::COLOR_BITS-1:0]      line_color,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [COORD_BITS-1:0]        pixel_x,
    output logic signed [COORD_BITS-1:0]        pixel_y,
    output logic                                write_enable,
    output logic [ADDR_BITS-1:0]                byte_address,
    output logic [lpg_pkg::COLOR_BITS-1:0]      pixel_color,
    output logic                                last_pixel
);
    import lpg_pkg::*;

    localparam int EW  = COORD_BITS + 2;
    localparam int CW  = (COORD_BITS > DIM_BITS ? COORD_BITS : DIM_BITS) + 1;
    localparam int RPW = STRIDE_BITS + COORD_BITS;
    localparam int XPW = COORD_BITS + BPP_BITS;
    localparam int PW  = RPW + 1;
    localparam int SW  = (ADDR_BITS > PW) ? ADDR_BITS : PW;

    // configuration
    logic [STRIDE_BITS-1:0] stride_reg;
    logic [BPP_BITS-1:0]    bpp_reg;
    logic [DIM_BITS-1:0]    width_reg;
    logic [DIM_BITS-1:0]    height_reg;
    logic                   cfg_write;
    reg_index_t             cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg <= STRIDE_RESET;
            bpp_reg    <= BPP_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_ROW_STRIDE:   stride_reg <= pwdata[STRIDE_BITS-1:0];
                REG_BYTES_PER_PX: bpp_reg    <= pwdata[BPP_BITS-1:0];
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[DIM_BITS-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[DIM_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_ROW_STRIDE:   prdata = APB_DATA_BITS'(stride_reg);
            REG_BYTES_PER_PX: prdata = APB_DATA_BITS'(bpp_reg);
            REG_IMAGE_WIDTH:  prdata = APB_DATA_BITS'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_BITS'(height_reg);
        endcase
    end

    // line state
    logic signed [COORD_BITS-1:0] cur_x_reg, cur_y_reg, tgt_x_reg, tgt_y_reg;
    logic signed [COORD_BITS-1:0] cur_x_next, cur_y_next, tgt_x_next, tgt_y_next;
    logic [COORD_BITS-1:0]        dx_reg, dy_reg, dx_next, dy_next;
    logic                         xneg_reg, yneg_reg, xneg_next, yneg_next;
    logic signed [EW-1:0]         err_reg, err_next;
    logic [COLOR_BITS-1:0]        color_reg, color_next;
    logic                         active_reg, active_next;
    logic                         pend_reg, pend_next;

    logic in_fire, is_start, stage_adv, take_state;

    assign is_start   = (kind_t'(kind) == KIND_START);
    assign stage_adv  = pend_reg && (!out_valid || out_ready);
    assign in_ready   = !pend_reg || stage_adv;
    assign in_fire    = in_valid && in_ready;
    assign take_state = in_fire && (is_start || active_reg);

    // start setup
    logic signed [COORD_BITS:0] sx_w, sy_w, ex_w, ey_w;
    logic [COORD_BITS:0]        adx_w, ady_w;
    logic [COORD_BITS-1:0]      s_dx, s_dy;
    logic signed [EW-1:0]       s_err;

    // advance step
    logic signed [EW:0]         e_w, dx_w, dy_w, e_new;
    logic                       step_x, step_y;
    logic signed [COORD_BITS-1:0] a_x, a_y;

    always_comb
    begin
        sx_w  = {start_x[COORD_BITS-1], start_x};
        sy_w  = {start_y[COORD_BITS-1], start_y};
        ex_w  = {end_x[COORD_BITS-1], end_x};
        ey_w  = {end_y[COORD_BITS-1], end_y};
        adx_w = (ex_w > sx_w) ? (ex_w - sx_w) : (sx_w - ex_w);
        ady_w = (ey_w > sy_w) ? (ey_w - sy_w) : (sy_w - ey_w);
        s_dx  = adx_w[COORD_BITS-1:0];
        s_dy  = ady_w[COORD_BITS-1:0];
        if (s_dx > s_dy)
            s_err = $signed({2'b00, s_dx >> 1});
        else
            s_err = -$signed({2'b00, s_dy >> 1});

        e_w    = {err_reg[EW-1], err_reg};
        dx_w   = $signed({3'b000, dx_reg});
        dy_w   = $signed({3'b000, dy_reg});
        step_x = (e_w > -dx_w);
        step_y = (e_w < dy_w);
        e_new  = e_w - (step_x ? dy_w : '0) + (step_y ? dx_w : '0);
        a_x    = step_x ? (xneg_reg ? cur_x_reg - COORD_BITS'(1) : cur_x_reg + COORD_BITS'(1))
                        : cur_x_reg;
        a_y    = step_y ? (yneg_reg ? cur_y_reg - COORD_BITS'(1) : cur_y_reg + COORD_BITS'(1))
                        : cur_y_reg;

        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        tgt_x_next  = tgt_x_reg;
        tgt_y_next  = tgt_y_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        xneg_next   = xneg_reg;
        yneg_next   = yneg_reg;
        err_next    = err_reg;
        color_next  = color_reg;
        active_next = active_reg;

        if (take_state)
        begin
            if (is_start)
            begin
                cur_x_next  = start_x;
                cur_y_next  = start_y;
                tgt_x_next  = end_x;
                tgt_y_next  = end_y;
                dx_next     = s_dx;
                dy_next     = s_dy;
                xneg_next   = !(start_x < end_x);
                yneg_next   = !(start_y < end_y);
                err_next    = s_err;
                color_next  = line_color;
                active_next = !((start_x == end_x) && (start_y == end_y));
            end
            else
            begin
                cur_x_next  = a_x;
                cur_y_next  = a_y;
                err_next    = e_new[EW-1:0];
                active_next = !((a_x == tgt_x_reg) && (a_y == tgt_y_reg));
            end
        end

        if (in_fire)
            pend_next = take_state;
        else if (stage_adv)
            pend_next = 1'b0;
        else
            pend_next = pend_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            tgt_x_reg  <= '0;
            tgt_y_reg  <= '0;
            dx_reg     <= '0;
            dy_reg     <= '0;
            xneg_reg   <= 1'b0;
            yneg_reg   <= 1'b0;
            err_reg    <= '0;
            color_reg  <= '0;
            active_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            tgt_x_reg  <= tgt_x_next;
            tgt_y_reg  <= tgt_y_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            xneg_reg   <= xneg_next;
            yneg_reg   <= yneg_next;
            err_reg    <= err_next;
            color_reg  <= color_next;
            active_reg <= active_next;
            pend_reg   <= pend_next;
        end
    end

    // pixel address and clipping
    logic                 in_bounds;
    logic [RPW-1:0]       row_prod;
    logic [XPW-1:0]       col_prod;
    logic [SW-1:0]        addr_sum;
    logic [ADDR_BITS-1:0] addr_px;

    always_comb
    begin
        in_bounds = !cur_x_reg[COORD_BITS-1] && !cur_y_reg[COORD_BITS-1]
                 && (CW'($unsigned(cur_x_reg)) < CW'(width_reg))
                 && (CW'($unsigned(cur_y_reg)) < CW'(height_reg));
        row_prod = RPW'(stride_reg) * RPW'($unsigned(cur_y_reg));
        col_prod = XPW'($unsigned(cur_x_reg)) * XPW'(bpp_reg);
        addr_sum = SW'(row_prod) + SW'(col_prod);
        addr_px  = in_bounds ? addr_sum[ADDR_BITS-1:0] : '0;
    end

    // output register
    logic out_valid_reg, out_valid_next;
    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic                         we_reg, last_reg;
    logic [ADDR_BITS-1:0]         addr_reg;
    logic [COLOR_BITS-1:0]        pcol_reg;

    always_comb
    begin
        if (stage_adv)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (stage_adv)
        begin
            px_reg   <= cur_x_reg;
            py_reg   <= cur_y_reg;
            we_reg   <= in_bounds;
            addr_reg <= addr_px;
            pcol_reg <= color_reg;
            last_reg <= !active_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = px_reg;
    assign pixel_y      = py_reg;
    assign write_enable = we_reg;
    assign byte_address = addr_reg;
    assign pixel_color  = pcol_reg;
    assign last_pixel   = last_reg;

    a_idle_advance_drops: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !is_start && !active_reg |=> !pend_reg)
        else $error("advance with no line produced a pixel");

    a_start_pends: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && is_start |=> pend_reg)
        else $error("start request produced no pixel");

    a_pend_holds: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && !stage_adv |=> pend_reg && $stable(cur_x_reg) && $stable(cur_y_reg))
        else $error("pending pixel lost under stall");

    a_clip_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_enable |-> byte_address == '0)
        else $error("clipped pixel carries an address");

    a_inside_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_enable |-> !pixel_x[COORD_BITS-1] && !pixel_y[COORD_BITS-1])
        else $error("negative coordinate marked inside");

endmodule
